/* hw/rtl/vvtp_pkg.sv */
// ----------------------------------------------------------------------------
// vvtp_pkg
// Shared types and constants for the vertex view transform and projection.
// ----------------------------------------------------------------------------
package vvtp_pkg;

  // Screen geometry; the projection centre is half of each dimension.
  localparam int ScreenWidth  = 1024;
  localparam int ScreenHeight = 768;
  localparam int CenterX      = ScreenWidth / 2;
  localparam int CenterY      = ScreenHeight / 2;

  // Datapath widths.
  localparam int CW = 16;  // coefficient and point coordinate
  localparam int PW = 32;  // coefficient times coordinate
  localparam int VW = 34;  // view coordinate, Q26.8 sum of three products and a bias
  localparam int NW = 51;  // focal length times view coordinate
  localparam int AW = 48;  // magnitude of the dividend
  localparam int BW = 32;  // magnitude of the divisor
  localparam int QB = 17;  // quotient bits kept; larger quotients saturate
  localparam int SW = 19;  // centre plus signed quotient

  // Register stages from the accepting edge to the result strobe.
  localparam int PipeDepth = 5 + QB + 1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ROW_ZERO = 2'd0,
    REG_ROW_ONE  = 2'd1,
    REG_ROW_TWO  = 2'd2,
    REG_FOCAL    = 2'd3
  } reg_idx_e;

  localparam logic [63:0] RowZeroReset = 64'h0000_0000_0000_0100;
  localparam logic [63:0] RowOneReset  = 64'h0000_0000_0100_0000;
  localparam logic [63:0] RowTwoReset  = 64'h0000_0100_0000_0000;
  localparam logic [15:0] FocalReset   = 16'd256;

endpackage

/* hw/rtl/vertex_view_transform_project_core.sv */
// ----------------------------------------------------------------------------
// vertex_view_transform_project_core
// A result strobe follows each accepted item through stages 1 to 5, the divide and the output register.
// Throughput: one item per cycle; busy is never raised and results cannot stall.
// The divide is a 17-stage restoring pipeline, one quotient bit per stage.
// Reset clears the valid bits and loads the identity view matrix, focal 256.
// ----------------------------------------------------------------------------
module vertex_view_transform_project_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [15:0]       point_x_i,
  input  logic signed [15:0]       point_y_i,
  input  logic signed [15:0]       point_height_i,
  output logic                     result_valid_o,
  output logic signed [15:0]       screen_x_o,
  output logic signed [15:0]       screen_y_o,
  output logic signed [31:0]       view_depth_o,
  output logic signed [15:0]       source_height_o,
  output logic                     depth_zero_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);
  import vvtp_pkg::*;

  // Configuration registers.
  logic [63:0] row_q [3];
  logic [15:0] focal_q;
  reg_idx_e    reg_idx;

  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowZeroReset;
      row_q[1] <= RowOneReset;
      row_q[2] <= RowTwoReset;
      focal_q  <= FocalReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROW_ZERO: row_q[0] <= pwdata;
        REG_ROW_ONE:  row_q[1] <= pwdata;
        REG_ROW_TWO:  row_q[2] <= pwdata;
        REG_FOCAL:    focal_q  <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (reg_idx)
      REG_ROW_ZERO: prdata = row_q[0];
      REG_ROW_ONE:  prdata = row_q[1];
      REG_ROW_TWO:  prdata = row_q[2];
      REG_FOCAL:    prdata = {48'd0, focal_q};
      default:      prdata = '0;
    endcase
  end

  // Stage 1: the nine coefficient products and the three bias terms.
  logic signed [CW-1:0] pt [3];
  logic signed [PW-1:0] prod1_q [3][3];
  logic signed [CW-1:0] bias1_q [3];
  logic signed [CW-1:0] hgt1_q;
  logic                 vld1_q;

  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_height_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod1_q[r][k] <= $signed(row_q[r][CW*k +: CW]) * pt[k];
      end
      bias1_q[r] <= $signed(row_q[r][CW*3 +: CW]);
    end
    hgt1_q <= point_height_i;
  end

  // Stage 2: the view coordinates as Q26.8 sums.
  logic signed [VW-1:0] v2_q [3];
  logic signed [CW-1:0] hgt2_q;
  logic                 vld2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      v2_q[r] <= VW'(prod1_q[r][0]) + VW'(prod1_q[r][1]) + VW'(prod1_q[r][2])
               + VW'(bias1_q[r]);
    end
    hgt2_q <= hgt1_q;
  end

  // Stage 3: focal scaling of x and y, depth integer part and zero check.
  logic signed [NW-1:0] n3_q [2];
  logic signed [VW-1:0] d3_q;
  logic signed [31:0]   depth3_q;
  logic                 zero3_q;
  logic signed [CW-1:0] hgt3_q;
  logic                 vld3_q;
  logic signed [VW-1:0] depth_rnd;
  logic signed [CW:0]   focal_s;

  assign focal_s   = $signed({1'b0, focal_q});
  // Truncation toward zero: bias negative depths before the arithmetic shift.
  assign depth_rnd = v2_q[2] + (v2_q[2][VW-1] ? VW'(255) : VW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n3_q[0]  <= NW'(focal_s * v2_q[0]);
    n3_q[1]  <= NW'(focal_s * v2_q[1]);
    d3_q     <= v2_q[2];
    depth3_q <= 32'(depth_rnd >>> 8);
    zero3_q  <= (v2_q[2] == '0);
    hgt3_q   <= hgt2_q;
  end

  // Stage 4: magnitudes and quotient signs.
  logic [AW-1:0]        a4_q [2];
  logic                 neg4_q [2];
  logic [BW-1:0]        b4_q;
  logic signed [31:0]   depth4_q;
  logic                 zero4_q;
  logic signed [CW-1:0] hgt4_q;
  logic                 vld4_q;
  logic [NW-1:0]        n_mag [2];
  logic [VW-1:0]        d_mag;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      n_mag[c] = n3_q[c][NW-1] ? NW'(-n3_q[c]) : NW'(n3_q[c]);
    end
    d_mag = d3_q[VW-1] ? VW'(-d3_q) : VW'(d3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      a4_q[c]   <= n_mag[c][AW-1:0];
      neg4_q[c] <= n3_q[c][NW-1] ^ d3_q[VW-1];
    end
    b4_q     <= d_mag[BW-1:0];
    depth4_q <= depth3_q;
    zero4_q  <= zero3_q;
    hgt4_q   <= hgt3_q;
  end

  // Stage 5: quotient range check, feeding the first divide stage.
  logic [AW-1:0]        rem_q [QB+1][2];
  logic [QB-1:0]        quo_q [QB+1][2];
  logic                 ovf_q [QB+1][2];
  logic                 neg_q [QB+1][2];
  logic [BW-1:0]        b_q   [QB+1];
  logic signed [31:0]   dep_q [QB+1];
  logic                 zro_q [QB+1];
  logic signed [CW-1:0] hgt_q [QB+1];
  logic                 vld_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      rem_q[0][c] <= a4_q[c];
      quo_q[0][c] <= '0;
      ovf_q[0][c] <= ({1'b0, a4_q[c]} >= {b4_q, QB'(0)});
      neg_q[0][c] <= neg4_q[c];
    end
    b_q[0]   <= b4_q;
    dep_q[0] <= depth4_q;
    zro_q[0] <= zero4_q;
    hgt_q[0] <= hgt4_q;
  end

  // Restoring divide, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int Shift = QB - 1 - j;
    logic [AW-1:0] trial;
    logic          ge [2];

    assign trial = AW'(b_q[j]) << Shift;

    always_comb begin
      for (int c = 0; c < 2; c++) begin
        ge[c] = (rem_q[j][c] >= trial);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 2; c++) begin
        rem_q[j+1][c] <= ge[c] ? (rem_q[j][c] - trial) : rem_q[j][c];
        quo_q[j+1][c] <= {quo_q[j][c][QB-2:0], ge[c]};
        ovf_q[j+1][c] <= ovf_q[j][c];
        neg_q[j+1][c] <= neg_q[j][c];
      end
      b_q[j+1]   <= b_q[j];
      dep_q[j+1] <= dep_q[j];
      zro_q[j+1] <= zro_q[j];
      hgt_q[j+1] <= hgt_q[j];
    end
  end

  // Output stage: sign, centre offset, saturation and the zero-depth case.
  logic signed [SW-1:0] center [2];
  logic signed [SW-1:0] qsig   [2];
  logic signed [SW-1:0] ssum   [2];
  logic signed [CW-1:0] scr    [2];
  logic signed [CW-1:0] scr_q  [2];
  logic signed [31:0]   dep_out_q;
  logic signed [CW-1:0] hgt_out_q;
  logic                 zro_out_q;
  logic                 vld_out_q;

  assign center[0] = SW'(CenterX);
  assign center[1] = SW'(CenterY);

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      qsig[c] = neg_q[QB][c] ? -$signed(SW'(quo_q[QB][c])) : $signed(SW'(quo_q[QB][c]));
      ssum[c] = center[c] + qsig[c];
      priority if (zro_q[QB]) begin
        scr[c] = '0;
      end else if (ovf_q[QB][c]) begin
        scr[c] = neg_q[QB][c] ? 16'sh8000 : 16'sh7fff;
      end else if (ssum[c] > $signed(SW'(32767))) begin
        scr[c] = 16'sh7fff;
      end else if (ssum[c] < -$signed(SW'(32768))) begin
        scr[c] = 16'sh8000;
      end else begin
        scr[c] = ssum[c][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    scr_q[0]  <= scr[0];
    scr_q[1]  <= scr[1];
    dep_out_q <= dep_q[QB];
    hgt_out_q <= hgt_q[QB];
    zro_out_q <= zro_q[QB];
  end

  assign result_valid_o  = vld_out_q;
  assign screen_x_o      = scr_q[0];
  assign screen_y_o      = scr_q[1];
  assign view_depth_o    = dep_out_q;
  assign source_height_o = hgt_out_q;
  assign depth_zero_o    = zro_out_q;

`ifndef ASSERT_OFF
  // Zero depth always yields zero screen coordinates.
  a_zero_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && depth_zero_o |-> screen_x_o == 16'sd0 && screen_y_o == 16'sd0)
    else $error("zero depth gave nonzero screen coordinates");

  // Every accepted item comes out after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##(PipeDepth - 1) result_valid_o)
    else $error("accepted item did not produce a result in time");

  // No result appears without an item accepted at the matching edge.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> ##(PipeDepth - 1) !result_valid_o)
    else $error("result strobe without an accepted item");

  // A nonzero integer depth never flags zero depth.
  a_depth_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && view_depth_o != 32'sd0 |-> !depth_zero_o)
    else $error("zero flag with nonzero depth");
`endif

endmodule
